// ----- rtl/core/slp_pkg.sv -----
package slp_pkg;

  localparam int SRC_WIDTH  = 160;
  localparam int SRC_HEIGHT = 144;
  localparam int DST_WIDTH  = 320;
  localparam int DST_HEIGHT = 240;

  localparam int COL_W   = 8;
  localparam int LINE_W  = 8;
  localparam int COLOR_W = 16;
  localparam int X_W     = 9;
  localparam int Y_W     = 8;

  localparam int ASPECT_W  = SRC_WIDTH + SRC_WIDTH / 2 + (SRC_WIDTH + 5) / 6;
  localparam int ASPECT_X0 = (DST_WIDTH - ASPECT_W) / 2;
  localparam int NORMAL_X0 = (DST_WIDTH - SRC_WIDTH) / 2;
  localparam int NORMAL_Y0 = (DST_HEIGHT - SRC_HEIGHT) / 2;

  typedef enum logic [1:0] {
    MODE_NORMAL  = 2'd0,
    MODE_STRETCH = 2'd1,
    MODE_ASPECT  = 2'd2
  } scale_mode_t;

  typedef struct packed {
    logic               in_range;
    logic [X_W-1:0]     x;
    logic [Y_W-1:0]     y;
    logic               dbl_x;
    logic               dbl_y;
    logic [COLOR_W-1:0] color;
  } wr_desc_t;

endpackage

// ----- rtl/core/scanline_pixel_scaler.sv -----
// Scanline pixel scaler: each accepted source pixel becomes one, two or four
// display writes, depending on the scaling mode and on whether its column and
// line are doubled. Writes leave one per cycle through the output register
// while the output is not stalled, and the next pixel is taken in the cycle
// its last write is loaded into the output register. An accepted pixel is held
// in a descriptor register, from which its writes are loaded into the output
// register one at a time. Pixels outside the source image produce no writes.
// The user must change the scaling mode only while no writes are pending;
// the block itself does not enforce this.
module scanline_pixel_scaler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // src_column, src_line, pixel_color
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // dest_x, dest_y, dest_color, zero fill
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata
);
  import slp_pkg::*;

  scale_mode_t        mode_r;
  wr_desc_t           desc;
  logic [X_W-1:0]     dest_x;
  logic [Y_W-1:0]     dest_y;
  logic [COLOR_W-1:0] dest_color;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_ASPECT;
    end else if (cfg_we) begin
      mode_r <= scale_mode_t'(cfg_wdata);
    end
  end

  slp_map u_map (
    .mode        (mode_r),
    .src_column  (in_tdata[7:0]),
    .src_line    (in_tdata[15:8]),
    .pixel_color (in_tdata[31:16]),
    .desc        (desc)
  );

  slp_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .desc_in    (desc),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .dest_x     (dest_x),
    .dest_y     (dest_y),
    .dest_color (dest_color),
    .last_write (out_tlast)
  );

  assign out_tdata = {7'b0000000, dest_color, dest_y, dest_x};

endmodule

// ----- rtl/core/slp_map.sv -----
module slp_map (
  input  slp_pkg::scale_mode_t          mode,
  input  logic [slp_pkg::COL_W-1:0]     src_column,
  input  logic [slp_pkg::LINE_W-1:0]    src_line,
  input  logic [slp_pkg::COLOR_W-1:0]   pixel_color,
  output slp_pkg::wr_desc_t             desc
);
  import slp_pkg::*;

  // Division by six through a reciprocal; exact for all values below 512.
  function automatic logic [7:0] div6(input logic [8:0] v);
    logic [16:0] prod;
    prod = v * 8'd171;
    return {1'b0, prod[16:10]};
  endfunction

  function automatic logic [7:0] hits_before(input logic [7:0] n);
    logic [8:0] n5;
    n5 = {1'b0, n} + 9'd5;
    return {1'b0, n[7:1]} + div6(n5);
  endfunction

  function automatic logic rule_hit(input logic [7:0] p);
    logic [7:0]  q;
    logic [10:0] six_q;
    logic [10:0] rem;
    q     = div6({1'b0, p});
    six_q = {q, 3'b000} - {2'b00, q, 1'b0};
    rem   = {3'b000, p} - six_q;
    return p[0] || (rem == 11'd0);
  endfunction

  logic [9:0] x_aspect;
  logic [9:0] x_normal;
  logic [8:0] y_stretch;
  logic [8:0] y_normal;

  always_comb begin
    x_aspect  = 10'(ASPECT_X0) + {2'b00, src_column} + {2'b00, hits_before(src_column)};
    x_normal  = 10'(NORMAL_X0) + {2'b00, src_column};
    y_stretch = {1'b0, src_line} + {1'b0, hits_before(src_line)};
    y_normal  = 9'(NORMAL_Y0) + {1'b0, src_line};

    desc.in_range = ({1'b0, src_column} < 9'(SRC_WIDTH)) &&
                    ({1'b0, src_line} < 9'(SRC_HEIGHT));
    desc.color    = pixel_color;

    case (mode)
      MODE_STRETCH: begin
        desc.x     = {src_column, 1'b0};
        desc.dbl_x = 1'b1;
        desc.y     = y_stretch[Y_W-1:0];
        desc.dbl_y = rule_hit(src_line);
      end
      MODE_ASPECT: begin
        desc.x     = x_aspect[X_W-1:0];
        desc.dbl_x = rule_hit(src_column);
        desc.y     = y_stretch[Y_W-1:0];
        desc.dbl_y = rule_hit(src_line);
      end
      default: begin
        desc.x     = x_normal[X_W-1:0];
        desc.dbl_x = 1'b0;
        desc.y     = y_normal[Y_W-1:0];
        desc.dbl_y = 1'b0;
      end
    endcase
  end

endmodule

// ----- rtl/core/slp_seq.sv -----
module slp_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  slp_pkg::wr_desc_t             desc_in,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [slp_pkg::X_W-1:0]       dest_x,
  output logic [slp_pkg::Y_W-1:0]       dest_y,
  output logic [slp_pkg::COLOR_W-1:0]   dest_color,
  output logic                          last_write
);
  import slp_pkg::*;

  logic               desc_valid_r, desc_valid_nxt;
  wr_desc_t           desc_r;
  logic [1:0]         step_r, step_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [X_W-1:0]     x_r;
  logic [Y_W-1:0]     y_r;
  logic [COLOR_W-1:0] color_r;
  logic               last_r;

  logic               emit;
  logic               cur_last;
  logic               desc_free;
  logic               load;

  always_comb begin
    emit      = desc_valid_r && (!out_valid_r || out_tready);
    cur_last  = (!desc_r.dbl_x || step_r[0]) && (!desc_r.dbl_y || step_r[1]);
    desc_free = !desc_valid_r || (emit && cur_last);
    load      = desc_free && in_tvalid;

    if (load) begin
      desc_valid_nxt = desc_in.in_range;
      step_nxt       = 2'b00;
    end else if (emit && cur_last) begin
      desc_valid_nxt = 1'b0;
      step_nxt       = 2'b00;
    end else if (emit) begin
      desc_valid_nxt = 1'b1;
      step_nxt       = (desc_r.dbl_x && !step_r[0]) ? {step_r[1], 1'b1} : 2'b10;
    end else begin
      desc_valid_nxt = desc_valid_r;
      step_nxt       = step_r;
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desc_valid_r <= 1'b0;
      step_r       <= 2'b00;
      out_valid_r  <= 1'b0;
    end else begin
      desc_valid_r <= desc_valid_nxt;
      step_r       <= step_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      desc_r <= desc_in;
    end
    if (emit) begin
      x_r     <= desc_r.x + {{(X_W-1){1'b0}}, step_r[0]};
      y_r     <= desc_r.y + {{(Y_W-1){1'b0}}, step_r[1]};
      color_r <= desc_r.color;
      last_r  <= cur_last;
    end
  end

  assign in_tready  = desc_free;
  assign out_tvalid = out_valid_r;
  assign dest_x     = x_r;
  assign dest_y     = y_r;
  assign dest_color = color_r;
  assign last_write = last_r;

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import slp_pkg::*;

  localparam int IDLE_PCT      = 28;
  localparam int RANDOM_PIXELS = 140;
  localparam int PHASES        = 5;
  localparam int SETTLE_CYCLES = 12;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int REPORT_MAX    = 10;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [LINE_W-1:0]  line;
    logic [COL_W-1:0]   col;
  } src_pixel_t;

  typedef struct packed {
    logic [X_W-1:0]     x;
    logic [Y_W-1:0]     y;
    logic [COLOR_W-1:0] color;
    logic               last;
  } disp_write_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_wdata = '0;

  src_pixel_t  pixel_q[$];
  disp_write_t write_q[$];
  logic [1:0]  scale_mode = MODE_ASPECT;
  logic [1:0]  phase_modes[PHASES] = '{MODE_NORMAL, MODE_STRETCH, MODE_UNUSED,
                                       MODE_ASPECT, MODE_STRETCH};
  bit          calm = 1'b0;
  bit          in_accepted = 1'b0;
  int          mismatches = 0;
  int          cycles = 0;

  scanline_pixel_scaler i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Positions that are odd or a multiple of six are repeated on the display.
  function automatic int repeats_before(int n);
    return n / 2 + (n + 5) / 6;
  endfunction

  function automatic int is_doubled(int p);
    return (p % 2 != 0 || p % 6 == 0) ? 1 : 0;
  endfunction

  task automatic predict_writes(src_pixel_t px);
    int col, line, x0, y0, xn, yn;
    disp_write_t w;
    col = int'(px.col);
    line = int'(px.line);
    if (col >= SRC_WIDTH || line >= SRC_HEIGHT) return;
    if (scale_mode == MODE_STRETCH) begin
      x0 = 2 * col;
      xn = 2;
      y0 = line + repeats_before(line);
      yn = 1 + is_doubled(line);
    end else if (scale_mode == MODE_ASPECT) begin
      x0 = (DST_WIDTH - SRC_WIDTH - repeats_before(SRC_WIDTH)) / 2 + col +
           repeats_before(col);
      xn = 1 + is_doubled(col);
      y0 = line + repeats_before(line);
      yn = 1 + is_doubled(line);
    end else begin
      x0 = (DST_WIDTH - SRC_WIDTH) / 2 + col;
      y0 = (DST_HEIGHT - SRC_HEIGHT) / 2 + line;
      xn = 1;
      yn = 1;
    end
    for (int j = 0; j < yn; j++) begin
      for (int i = 0; i < xn; i++) begin
        w.x = X_W'(x0 + i);
        w.y = Y_W'(y0 + j);
        w.color = px.color;
        w.last = (j == yn - 1 && i == xn - 1);
        write_q.push_back(w);
      end
    end
  endtask

  function automatic src_pixel_t random_pixel();
    src_pixel_t px;
    px.color = COLOR_W'($urandom_range(16'hFFFF));
    if ($urandom_range(99) < 8) begin
      px.col = COL_W'($urandom_range(255));
      px.line = LINE_W'($urandom_range(255));
    end else begin
      px.col = COL_W'($urandom_range(SRC_WIDTH - 1));
      px.line = LINE_W'($urandom_range(SRC_HEIGHT - 1));
    end
    return px;
  endfunction

  always @(negedge clk) begin
    int idle;
    idle = calm ? 0 : IDLE_PCT;
    out_tready <= rst_n && ($urandom_range(99) >= idle);
    if (!in_tvalid || in_accepted) begin
      if (rst_n && pixel_q.size() > 0 && $urandom_range(99) >= idle) begin
        in_tdata <= pixel_q.pop_front();
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    disp_write_t got, want;
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("scanline_pixel_scaler test failed");
      $finish;
    end else begin
      in_accepted <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) predict_writes(in_tdata);
      if (rst_n && out_tvalid && out_tready) begin
        got.x = out_tdata[X_W-1:0];
        got.y = out_tdata[X_W +: Y_W];
        got.color = out_tdata[X_W+Y_W +: COLOR_W];
        got.last = out_tlast;
        if (write_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("unexpected write x=%0d y=%0d color=%h last=%b",
                     got.x, got.y, got.color, got.last);
        end else begin
          want = write_q.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.color !== want.color ||
              got.last !== want.last) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("mismatch: exp x=%0d y=%0d c=%h l=%b, got x=%0d y=%0d c=%h l=%b",
                       want.x, want.y, want.color, want.last,
                       got.x, got.y, got.color, got.last);
          end
        end
      end
    end
  end

  // Waits for every pixel to be taken and every write to arrive, then lets
  // the block settle before returning.
  task automatic wait_drained();
    while (pixel_q.size() > 0 || in_tvalid || write_q.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(logic [1:0] mode);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= mode;
    @(negedge clk);
    cfg_we <= 1'b0;
    scale_mode = mode;
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // The reset mode keeps the aspect ratio, so the directed pixels run under it.
    pixel_q.push_back('{col: 8'd0,   line: 8'd0,   color: 16'h0000});
    pixel_q.push_back('{col: 8'd159, line: 8'd143, color: 16'hFFFF});
    pixel_q.push_back('{col: 8'd1,   line: 8'd1,   color: 16'hAAAA});
    pixel_q.push_back('{col: 8'd2,   line: 8'd2,   color: 16'h5555});
    pixel_q.push_back('{col: 8'd4,   line: 8'd6,   color: 16'hF800});
    pixel_q.push_back('{col: 8'd6,   line: 8'd4,   color: 16'h07E0});
    pixel_q.push_back('{col: 8'd12,  line: 8'd12,  color: 16'h001F});
    pixel_q.push_back('{col: 8'd158, line: 8'd142, color: 16'h8001});
    pixel_q.push_back('{col: 8'd128, line: 8'd128, color: 16'h7FFE});
    pixel_q.push_back('{col: 8'd160, line: 8'd0,   color: 16'h1234});
    pixel_q.push_back('{col: 8'd0,   line: 8'd144, color: 16'h4321});
    pixel_q.push_back('{col: 8'd255, line: 8'd255, color: 16'hFFFF});
    pixel_q.push_back('{col: 8'd159, line: 8'd0,   color: 16'h0000});
    pixel_q.push_back('{col: 8'd0,   line: 8'd143, color: 16'hFFFF});
    pixel_q.push_back('{col: 8'd3,   line: 8'd5,   color: 16'hC3C3});
    pixel_q.push_back('{col: 8'd5,   line: 8'd3,   color: 16'h3C3C});
    pixel_q.push_back('{col: 8'd100, line: 8'd101, color: 16'h0F0F});
    pixel_q.push_back('{col: 8'd127, line: 8'd127, color: 16'hF0F0});
    pixel_q.push_back('{col: 8'd84,  line: 8'd90,  color: 16'h8000});
    pixel_q.push_back('{col: 8'd200, line: 8'd50,  color: 16'h0001});
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      write_mode(phase_modes[p]);
      calm = (p == 3);
      for (int n = 0; n < RANDOM_PIXELS / PHASES; n++) begin
        if (p == 1 && n == 16) wait_drained();
        pixel_q.push_back(random_pixel());
      end
      wait_drained();
    end

    if (mismatches == 0 && write_q.size() == 0) begin
      $display("scanline_pixel_scaler test passed");
    end else begin
      $display("scanline_pixel_scaler test failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/slp_pkg.sv
rtl/core/slp_map.sv
rtl/core/slp_seq.sv
rtl/core/scanline_pixel_scaler.sv
tb/sv/testbench.sv
